FILE: design/sbr_pkg.sv
// ----------------------------------------------------------------------------
// sbr_pkg
// Shared widths and types of the stream byte reassembler.
// ----------------------------------------------------------------------------
package sbr_pkg;

  localparam int IDX_W  = 32;
  localparam int BYTE_W = 8;
  localparam int FREE_W = 6;
  localparam int PEND_W = 6;
  // An offset that is stored is always below free_space, so it fits in FREE_W bits.
  localparam int OFF_W  = FREE_W;

  // One classified request, passed from the front part to the back part.
  typedef struct packed {
    logic [OFF_W-1:0]  off;
    logic [BYTE_W-1:0] data;
    logic              store;
    logic              seg_last;
    logic              eos;
  } sbr_entry_t;

  // Status that the back part reports to the front part.
  typedef struct packed {
    logic             drain_done;
    logic [IDX_W-1:0] next_index;
  } sbr_status_t;

endpackage

FILE: design/sbr_front.sv
// ----------------------------------------------------------------------------
// sbr_front
// Accepts requests, checks them against the receive window and queues them.
// ----------------------------------------------------------------------------
module sbr_front #(
  parameter int CAPACITY = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic [sbr_pkg::IDX_W-1:0]  stream_index,
  input  logic [sbr_pkg::BYTE_W-1:0] data_byte,
  input  logic                       byte_valid,
  input  logic                       segment_last,
  input  logic                       end_of_stream,
  input  logic [sbr_pkg::FREE_W-1:0] free_space,
  input  sbr_pkg::sbr_status_t       status,
  input  logic                       q_full,
  output logic                       push,
  output sbr_pkg::sbr_entry_t        entry
);
  import sbr_pkg::*;

  logic             drain_wait;
  logic [IDX_W:0]   diff;
  logic             behind;
  logic             in_window;

  // The borrow of the subtraction tells a position before next_index.
  assign diff      = {1'b0, stream_index} - {1'b0, status.next_index};
  assign behind    = diff[IDX_W];
  assign in_window = !behind && (diff[IDX_W-1:0] < IDX_W'(CAPACITY))
                     && (diff[IDX_W-1:0] < IDX_W'(free_space));

  // After a segment end the window moves, so nothing more is taken until
  // the back part has finished that drain.
  assign item_stall = q_full || drain_wait;
  assign push       = item_valid && !item_stall;

  always_comb begin
    entry.off      = diff[OFF_W-1:0];
    entry.data     = data_byte;
    entry.store    = byte_valid && in_window;
    entry.seg_last = segment_last;
    entry.eos      = end_of_stream;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drain_wait <= 1'b0;
    end else if (push && segment_last) begin
      drain_wait <= 1'b1;
    end else if (status.drain_done) begin
      drain_wait <= 1'b0;
    end
  end

endmodule

FILE: design/sbr_queue.sv
// ----------------------------------------------------------------------------
// sbr_queue
// Two-entry queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module sbr_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sbr_pkg::sbr_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output sbr_pkg::sbr_entry_t head_entry
);
  import sbr_pkg::*;

  sbr_entry_t  slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;

  assign full       = (fill == 2'd2);
  assign empty      = (fill == 2'd0);
  assign head_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: design/sbr_back.sv
// ----------------------------------------------------------------------------
// sbr_back
// Stores window bytes and drains the contiguous run at each segment end.
// ----------------------------------------------------------------------------
module sbr_back #(
  parameter int CAPACITY = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  sbr_pkg::sbr_entry_t        q_entry,
  output logic                       pop,
  output sbr_pkg::sbr_status_t       status,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic [sbr_pkg::BYTE_W-1:0] out_byte,
  output logic                       out_valid,
  output logic                       stream_end,
  output logic [sbr_pkg::PEND_W-1:0] pending_count,
  output logic                       last
);
  import sbr_pkg::*;

  localparam int HW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_READ  = 5'b00100,
    S_SEND  = 5'b01000,
    S_EMPTY = 5'b10000
  } state_t;

  state_t             state;
  logic [BYTE_W-1:0]  byte_store [CAPACITY];
  logic [BYTE_W-1:0]  rdata;
  logic [CAPACITY-1:0] filled;
  logic [HW-1:0]      head;
  logic [HW-1:0]      scan_ptr;
  logic [CW-1:0]      count;
  logic [CW-1:0]      remain;
  logic [CW-1:0]      unassembled;
  logic [CW-1:0]      pend;
  logic               end_flag;
  logic               eos_r;
  logic [IDX_W-1:0]   next_index;

  logic [HW-1:0]      off_w;
  logic [HW:0]        slot_sum;
  logic [HW-1:0]      store_slot;
  logic               store_en;
  logic               rd_en;
  logic               load;
  logic               scan_hit;
  logic [CW-1:0]      pend_next;

  function automatic logic [HW-1:0] wrap_inc(input logic [HW-1:0] p);
    return (p == HW'(CAPACITY - 1)) ? '0 : p + 1'b1;
  endfunction

  assign off_w      = q_entry.off[HW-1:0];
  assign slot_sum   = {1'b0, head} + {1'b0, off_w};
  assign store_slot = (slot_sum >= (HW+1)'(CAPACITY)) ?
                      HW'(slot_sum - (HW+1)'(CAPACITY)) : slot_sum[HW-1:0];

  assign pop      = (state == S_IDLE) && !q_empty;
  assign store_en = pop && q_entry.store && !filled[store_slot];
  assign load     = (!result_valid || !result_stall) &&
                    ((state == S_SEND) || (state == S_EMPTY));
  assign rd_en    = (state == S_READ) ||
                    ((state == S_SEND) && load && (remain != '0));
  assign scan_hit = (count != CW'(CAPACITY)) && filled[scan_ptr];
  assign pend_next = unassembled - count;

  assign status.next_index = next_index;
  assign status.drain_done = load && ((state == S_EMPTY) || (remain == '0));

  // Byte window memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (store_en) begin
      byte_store[store_slot] <= q_entry.data;
    end
    if (rd_en) begin
      rdata <= byte_store[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      filled      <= '0;
      head        <= '0;
      scan_ptr    <= '0;
      count       <= '0;
      remain      <= '0;
      unassembled <= '0;
      pend        <= '0;
      end_flag    <= 1'b0;
      eos_r       <= 1'b0;
      next_index  <= '0;
    end else begin
      if (store_en) begin
        filled[store_slot] <= 1'b1;
        unassembled        <= unassembled + 1'b1;
      end
      if (rd_en) begin
        filled[head] <= 1'b0;
        head         <= wrap_inc(head);
        remain       <= remain - 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (pop && q_entry.seg_last) begin
            state    <= S_SCAN;
            scan_ptr <= head;
            count    <= '0;
            eos_r    <= q_entry.eos;
          end
        end
        S_SCAN: begin
          // Count the filled run at the head, one slot per cycle.
          if (scan_hit) begin
            count    <= count + 1'b1;
            scan_ptr <= wrap_inc(scan_ptr);
          end else begin
            unassembled <= pend_next;
            next_index  <= next_index + IDX_W'(count);
            remain      <= count;
            pend        <= pend_next;
            end_flag    <= eos_r && (pend_next == '0);
            state       <= (count == '0) ? S_EMPTY : S_READ;
          end
        end
        S_READ: begin
          state <= S_SEND;
        end
        S_SEND: begin
          if (load && (remain == '0)) begin
            state <= S_IDLE;
          end
        end
        S_EMPTY: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte      <= (state == S_SEND) ? rdata : '0;
      out_valid     <= (state == S_SEND);
      stream_end    <= end_flag;
      pending_count <= PEND_W'(pend);
      last          <= (state == S_EMPTY) || (remain == '0);
    end
  end

endmodule

FILE: design/stream_byte_reassembler_unit.sv
// Results: a segment end that drains bytes passes the queue, run scan, store read and
//   send state before its first result; with nothing to drain it gives one empty
//   result. Other requests give no result. Input: non-segment-end requests go in
//   one per cycle while the queue has room; a segment end stalls input until its
//   drain is done (run scan, then one byte per cycle while results are not stalled).
// Reset: synchronous; clears the window marks, indexes and queue; the byte
//   store keeps its contents.
// ----------------------------------------------------------------------------
// stream_byte_reassembler_unit
// Rebuilds an in-order byte stream from bytes that arrive out of order.
// ----------------------------------------------------------------------------
module stream_byte_reassembler_unit #(
  parameter int CAPACITY = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic [sbr_pkg::IDX_W-1:0]  stream_index,
  input  logic [sbr_pkg::BYTE_W-1:0] data_byte,
  input  logic                       byte_valid,
  input  logic                       segment_last,
  input  logic                       end_of_stream,
  input  logic [sbr_pkg::FREE_W-1:0] free_space,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic [sbr_pkg::BYTE_W-1:0] out_byte,
  output logic                       out_valid,
  output logic                       stream_end,
  output logic [sbr_pkg::PEND_W-1:0] pending_count,
  output logic                       last
);
  import sbr_pkg::*;

  sbr_status_t status;
  sbr_entry_t  push_entry;
  sbr_entry_t  head_entry;
  logic        push;
  logic        pop;
  logic        q_full;
  logic        q_empty;

  sbr_front #(.CAPACITY(CAPACITY)) u_front (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .stream_index  (stream_index),
    .data_byte     (data_byte),
    .byte_valid    (byte_valid),
    .segment_last  (segment_last),
    .end_of_stream (end_of_stream),
    .free_space    (free_space),
    .status        (status),
    .q_full        (q_full),
    .push          (push),
    .entry         (push_entry)
  );

  sbr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .empty      (q_empty),
    .head_entry (head_entry)
  );

  sbr_back #(.CAPACITY(CAPACITY)) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_entry       (head_entry),
    .pop           (pop),
    .status        (status),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .out_byte      (out_byte),
    .out_valid     (out_valid),
    .stream_end    (stream_end),
    .pending_count (pending_count),
    .last          (last)
  );

endmodule

FILE: design/sbr_checker.sv
// ----------------------------------------------------------------------------
// sbr_checker
// Port-level checks of the stream byte reassembler, bound to the top level.
// ----------------------------------------------------------------------------
module sbr_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       item_valid,
  input logic                       item_stall,
  input logic                       segment_last,
  input logic                       result_valid,
  input logic                       result_stall,
  input logic [sbr_pkg::BYTE_W-1:0] out_byte,
  input logic                       out_valid,
  input logic                       stream_end,
  input logic [sbr_pkg::PEND_W-1:0] pending_count,
  input logic                       last
);
  import sbr_pkg::*;

  // A stalled result stays in place unchanged.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(out_byte)
      && $stable(last) && $stable(pending_count) && $stable(stream_end))
    else $error("stalled result changed");

  // A result without a byte only comes from an empty drain, which is its own last.
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !out_valid |-> last)
    else $error("empty result not marked last");

  // Stream end means nothing is left waiting.
  a_end_no_pending: assert property (@(posedge clk) disable iff (rst)
    result_valid && stream_end |-> pending_count == '0)
    else $error("stream end with bytes pending");

  // Once a segment end is taken, input is held while it drains.
  a_hold_after_seg_end: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && segment_last |=> item_stall)
    else $error("request taken during a drain");

endmodule

bind stream_byte_reassembler_unit sbr_checker u_sbr_checker (
  .clk           (clk),
  .rst           (rst),
  .item_valid    (item_valid),
  .item_stall    (item_stall),
  .segment_last  (segment_last),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .out_byte      (out_byte),
  .out_valid     (out_valid),
  .stream_end    (stream_end),
  .pending_count (pending_count),
  .last          (last)
);
